// ----- src/tld_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and codes for the terminal line discipline.
// Used by the controller, the datapath and the top level.
package tld_pkg;

  localparam int LINE_CAPACITY_DEF = 16;
  localparam int MAX_RESULTS       = 48;
  localparam int TRIPLE_MAX        = MAX_RESULTS / 3;

  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_SP = 8'h20;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  localparam logic [7:0] RST_ERASE_CHAR = 8'd8;
  localparam logic [7:0] RST_KILL_CHAR  = 8'd21;
  localparam logic [7:0] RST_EOF_CHAR   = 8'd4;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CANON = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONLCR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EOF   = 3'd5;

  localparam logic [2:0] SEL_BYTE = 3'd0;
  localparam logic [2:0] SEL_CR   = 3'd1;
  localparam logic [2:0] SEL_BS   = 3'd2;
  localparam logic [2:0] SEL_SP   = 3'd3;
  localparam logic [2:0] SEL_LINE = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_master;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       to_slave;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       in_load;
    logic       wr_store;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       idx_clr;
    logic       idx_inc;
    logic       rep_load_all;
    logic       rep_load_one;
    logic       rep_dec;
    logic       emit;
    logic [2:0] sel;
    logic       emit_slave;
    logic       emit_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic master;
    logic canon;
    logic echo;
    logic onlcr;
    logic is_kill;
    logic is_erase;
    logic is_eof;
    logic is_lf;
    logic cnt_zero;
    logic cnt_full_next;
    logic cnt_at_cap;
    logic flush_last;
    logic rep_one;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/tld_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: configuration registers, line store, line counters and the output register.
// Depends on tld_pkg; driven by tld_controller through ctl_cmd_t.
module tld_datapath import tld_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_cmd_t             cmd,
  output dp_stat_t             stat,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  localparam int CNT_W   = $clog2(LINE_CAPACITY + 1);
  localparam int IDX_W   = $clog2(LINE_CAPACITY);
  localparam int REP_CAP = (LINE_CAPACITY - 1 < TRIPLE_MAX) ? LINE_CAPACITY - 1 : TRIPLE_MAX;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(LINE_CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(LINE_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic             canon_r, echo_r, onlcr_r;
  logic [7:0]       erase_r, kill_r, eof_r;
  logic [7:0]       byte_r;
  logic             master_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] rep_r, rep_nxt;
  logic [CNT_W-1:0] rep_all;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       line_mem [LINE_CAPACITY];
  logic [7:0]       rd_data_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             out_free;
  logic [7:0]       emit_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canon_r <= 1'b1;
      echo_r  <= 1'b1;
      onlcr_r <= 1'b1;
      erase_r <= RST_ERASE_CHAR;
      kill_r  <= RST_KILL_CHAR;
      eof_r   <= RST_EOF_CHAR;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CANON: canon_r <= cfg_data[0];
        CFG_ECHO:  echo_r  <= cfg_data[0];
        CFG_ONLCR: onlcr_r <= cfg_data[0];
        CFG_ERASE: erase_r <= cfg_data;
        CFG_KILL:  kill_r  <= cfg_data;
        CFG_EOF:   eof_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      byte_r   <= in_data.data_byte;
      master_r <= in_data.from_master;
    end
  end

  assign rep_all = (count_r > CNT_W'(REP_CAP)) ? CNT_W'(REP_CAP) : count_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_ONE;
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_ONE;
    end
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc && idx_r != IDX_MAX) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    rep_nxt = rep_r;
    if (cmd.rep_load_all) begin
      rep_nxt = rep_all;
    end else if (cmd.rep_load_one) begin
      rep_nxt = CNT_ONE;
    end else if (cmd.rep_dec) begin
      rep_nxt = rep_r - CNT_ONE;
    end
  end

  assign rd_addr = idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      rep_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      rep_r   <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_store) begin
      line_mem[count_r[IDX_W-1:0]] <= byte_r;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (cmd.sel)
      SEL_BYTE: emit_byte = byte_r;
      SEL_CR:   emit_byte = BYTE_CR;
      SEL_BS:   emit_byte = BYTE_BS;
      SEL_SP:   emit_byte = BYTE_SP;
      SEL_LINE: emit_byte = rd_data_r;
      default:  emit_byte = byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && cmd.emit) begin
      out_data_r.out_byte <= emit_byte;
      out_data_r.to_slave <= cmd.emit_slave;
      out_data_r.last     <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat.master        = master_r;
    stat.canon         = canon_r;
    stat.echo          = echo_r;
    stat.onlcr         = onlcr_r;
    stat.is_kill       = byte_r == kill_r;
    stat.is_erase      = byte_r == erase_r;
    stat.is_eof        = byte_r == eof_r;
    stat.is_lf         = byte_r == BYTE_LF;
    stat.cnt_zero      = count_r == '0;
    stat.cnt_full_next = (count_r + CNT_ONE) == CNT_CAP;
    stat.cnt_at_cap    = count_r == CNT_CAP;
    stat.flush_last    = (CNT_W'(idx_r) + CNT_ONE) == count_r;
    stat.rep_one       = rep_r == CNT_ONE;
    stat.out_free      = out_free;
  end

  // The line count stays below capacity between bytes.
  a_count_between: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.in_load |-> count_r < CNT_CAP) else $error("line count at capacity on new byte");

  // A store never lands beyond the line.
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_store |-> count_r < CNT_CAP) else $error("line store overflow");

  // A flush never reads past the buffered bytes.
  a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.idx_inc |-> CNT_W'(idx_r) < count_r) else $error("flush read past line");

  // An accepted emit always shows up on the output register.
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && out_free) |=> out_valid_r) else $error("emitted beat lost");

endmodule

// ----- src/tld_controller.sv -----
`timescale 1ns / 1ps
// Controller state machine: classifies each byte and sequences its result beats.
// Depends on tld_pkg; commands tld_datapath and reads its status.
module tld_controller import tld_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_CLASS     = 4'd1;
  localparam logic [3:0] ST_CR        = 4'd2;
  localparam logic [3:0] ST_SLV       = 4'd3;
  localparam logic [3:0] ST_RAW_ECHO  = 4'd4;
  localparam logic [3:0] ST_PASS      = 4'd5;
  localparam logic [3:0] ST_ECHO      = 4'd6;
  localparam logic [3:0] ST_BS1       = 4'd7;
  localparam logic [3:0] ST_SP        = 4'd8;
  localparam logic [3:0] ST_BS2       = 4'd9;
  localparam logic [3:0] ST_FLUSH_PRE = 4'd10;
  localparam logic [3:0] ST_FLUSH     = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_BYTE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (!stat.master) begin
          state_nxt = (stat.is_lf && stat.onlcr) ? ST_CR : ST_SLV;
        end else if (!stat.canon) begin
          state_nxt = stat.echo ? ST_RAW_ECHO : ST_PASS;
        end else if (stat.is_kill) begin
          cmd.cnt_clr = 1'b1;
          if (!stat.cnt_zero && stat.echo) begin
            cmd.rep_load_all = 1'b1;
            state_nxt        = ST_BS1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (stat.is_erase) begin
          state_nxt = ST_IDLE;
          if (!stat.cnt_zero) begin
            cmd.cnt_dec = 1'b1;
            if (stat.echo) begin
              cmd.rep_load_one = 1'b1;
              state_nxt        = ST_BS1;
            end
          end
        end else if (stat.is_eof) begin
          state_nxt = ST_IDLE;
          if (!stat.cnt_zero) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = ST_FLUSH_PRE;
          end
        end else begin
          cmd.wr_store = 1'b1;
          cmd.cnt_inc  = 1'b1;
          cmd.idx_clr  = 1'b1;
          if (stat.echo) begin
            state_nxt = ST_ECHO;
          end else if (stat.cnt_full_next || stat.is_lf) begin
            state_nxt = ST_FLUSH_PRE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CR: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_CR;
        if (stat.out_free) begin
          state_nxt = ST_SLV;
        end
      end
      ST_SLV: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RAW_ECHO: begin
        cmd.emit = 1'b1;
        if (stat.out_free) begin
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        cmd.emit       = 1'b1;
        cmd.emit_slave = 1'b1;
        cmd.emit_last  = 1'b1;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ECHO: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = !(stat.is_lf || stat.cnt_at_cap);
        if (stat.out_free) begin
          state_nxt = (stat.is_lf || stat.cnt_at_cap) ? ST_FLUSH_PRE : ST_IDLE;
        end
      end
      ST_BS1: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_BS;
        if (stat.out_free) begin
          state_nxt = ST_SP;
        end
      end
      ST_SP: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_SP;
        if (stat.out_free) begin
          state_nxt = ST_BS2;
        end
      end
      ST_BS2: begin
        cmd.emit      = 1'b1;
        cmd.sel       = SEL_BS;
        cmd.emit_last = stat.rep_one;
        if (stat.out_free) begin
          cmd.rep_dec = 1'b1;
          state_nxt   = stat.rep_one ? ST_IDLE : ST_BS1;
        end
      end
      ST_FLUSH_PRE: begin
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.emit       = 1'b1;
        cmd.sel        = SEL_LINE;
        cmd.emit_slave = 1'b1;
        cmd.emit_last  = stat.flush_last;
        if (stat.out_free) begin
          cmd.idx_inc = 1'b1;
          if (stat.flush_last) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/terminal_line_discipline.sv -----
`timescale 1ns / 1ps
// Terminal line discipline top level: a pseudo-terminal byte engine.
// Depends on tld_pkg, tld_controller and tld_datapath.
//
// The input channel (in_valid, in_ready, in_data) takes one byte per beat,
// tagged with the side that wrote it. The output channel (out_valid,
// out_ready, out_data) gives result bytes, each tagged with its destination
// queue, and marks the final result of an input byte with last. Bytes that
// cause no result produce no output beat. The configuration channel (cfg_*)
// writes one register per beat and is always ready; write it only when idle.
// One byte is processed at a time: an accepted byte is registered, then
// classified, then its results leave one beat at a time, and a flushed
// line first primes the line store read. While the receiver is ready, the
// flush streams one stored byte per cycle from the line store read port.
// Reset restores the register defaults and empties the line; the line store
// itself needs no clearing. When the receiver stalls, the output register
// holds its beat and the controller waits; no result is dropped.
module terminal_line_discipline import tld_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tld_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tld_datapath #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
